@@ rtl/core/spe_pkg.sv @@
`timescale 1ns / 1ps

package spe_pkg;

  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int PLEN_W     = 6;
  localparam int PIDX_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_WORDS  = 4;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_W0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_W1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_W2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_W3  = 3'd4;

  typedef struct packed {
    logic [PLEN_W-1:0] eff_len;
    logic [CHAR_W-1:0] last_char;
  } pat_info_t;

endpackage

@@ rtl/core/spe_if.sv @@
`timescale 1ns / 1ps

interface spe_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [spe_pkg::CHAR_W-1:0] char_in;
  logic [spe_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, output req_type, output char_in, output read_index,
                  input ready);
  modport sink   (input valid, input req_type, input char_in, input read_index,
                  output ready);
endinterface

interface spe_out_if;
  logic                       valid;
  logic                       ready;
  logic [spe_pkg::CHAR_W-1:0] char_out;
  logic [spe_pkg::LEN_W-1:0]  stack_length;
  logic                       erased;
  logic                       overflow;
  logic                       index_invalid;

  modport source (output valid, output char_out, output stack_length, output erased,
                  output overflow, output index_invalid, input ready);
  modport sink   (input valid, input char_out, input stack_length, input erased,
                  input overflow, input index_invalid, output ready);
endinterface

@@ rtl/core/spe_pattern_regs.sv @@
`timescale 1ns / 1ps

module spe_pattern_regs #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [spe_pkg::PIDX_W-1:0]     sel_idx,
  output logic [spe_pkg::CHAR_W-1:0]     sel_char,
  output spe_pkg::pat_info_t             pat_info
);

  localparam int PLW = spe_pkg::PLEN_W;
  localparam int CW  = spe_pkg::CHAR_W;

  logic [PLW-1:0]                 pat_len_r;
  logic [spe_pkg::CFG_DATA_W-1:0] pat_words_r [spe_pkg::PAT_WORDS];
  logic [PLW-1:0]                 len_min;
  logic [PLW-1:0]                 eff_len;
  logic [spe_pkg::PIDX_W-1:0]     last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r <= PLW'(1);
      for (int i = 0; i < spe_pkg::PAT_WORDS; i++) pat_words_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spe_pkg::CFG_PAT_LEN: pat_len_r      <= cfg_wdata[PLW-1:0];
        spe_pkg::CFG_PAT_W0:  pat_words_r[0] <= cfg_wdata;
        spe_pkg::CFG_PAT_W1:  pat_words_r[1] <= cfg_wdata;
        spe_pkg::CFG_PAT_W2:  pat_words_r[2] <= cfg_wdata;
        spe_pkg::CFG_PAT_W3:  pat_words_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero length acts as one, anything beyond the maximum is clamped
  always_comb begin
    len_min  = (pat_len_r == '0) ? PLW'(1) : pat_len_r;
    eff_len  = (len_min > PLW'(PATTERN_MAX)) ? PLW'(PATTERN_MAX) : len_min;
    last_idx = spe_pkg::PIDX_W'(eff_len - PLW'(1));
  end

  assign sel_char           = pat_words_r[sel_idx[4:3]][sel_idx[2:0]*CW +: CW];
  assign pat_info.eff_len   = eff_len;
  assign pat_info.last_char = pat_words_r[last_idx[4:3]][last_idx[2:0]*CW +: CW];

endmodule

@@ rtl/core/stack_pattern_eraser_unit.sv @@
`timescale 1ns / 1ps

// Character stack that erases a configured pattern (up to PATTERN_MAX characters) each
// time it appears on top, so erasures cascade. One request at a time, one result beat
// per request. A push runs from its accept beat through S_EMIT to a loaded result; when
// the pushed character equals the pattern's last character and the stack holds at least
// n characters (n the effective pattern length, above one) a backward compare in S_CMP
// over the n-1 entries below comes between, one stack entry a cycle through the single
// read port of the stack memory. A read in range passes S_READ for the memory read
// before S_EMIT; an out-of-range read, clear, overflowing push and unused request codes
// go straight to S_EMIT. The output register lets the next request be accepted while a
// result waits. The stack memory needs no clearing after reset.
module stack_pattern_eraser_unit #(
  parameter int STACK_DEPTH = 4096,
  parameter int PATTERN_MAX = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spe_in_if.sink                         in_chan,
  spe_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int TW  = $clog2(STACK_DEPTH + 1);
  localparam int IW  = spe_pkg::IDX_W;
  localparam int XW  = (TW > IW) ? TW : IW;
  localparam int LW  = spe_pkg::LEN_W;
  localparam int CW  = spe_pkg::CHAR_W;
  localparam int PW  = spe_pkg::PIDX_W;
  localparam int PLW = spe_pkg::PLEN_W;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_EMIT} state_t;

  state_t         state_r, state_nxt;
  logic [TW-1:0]  top_r, top_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [PW-1:0]  pidx_r, pidx_nxt;
  logic [CW-1:0]  res_char_r, res_char_nxt;
  logic           res_erased_r, res_erased_nxt;
  logic           res_ovf_r, res_ovf_nxt;
  logic           res_inv_r, res_inv_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [CW-1:0]  out_char_r, out_char_nxt;
  logic [LW-1:0]  out_len_r, out_len_nxt;
  logic           out_erased_r, out_erased_nxt;
  logic           out_ovf_r, out_ovf_nxt;
  logic           out_inv_r, out_inv_nxt;

  logic [CW-1:0]  stack_mem [STACK_DEPTH];
  logic [CW-1:0]  rd_data_r;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;

  spe_pkg::pat_info_t pat_info;
  logic [CW-1:0]      pat_char;
  logic [TW-1:0]      top_inc;
  logic [TW-1:0]      eff_len_t;
  logic [XW-1:0]      idx_ext;
  logic [XW-1:0]      top_ext;

  spe_pattern_regs #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_pat (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .sel_idx   (pidx_r),
    .sel_char  (pat_char),
    .pat_info  (pat_info)
  );

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[top_r[AW-1:0]] <= in_chan.char_in;
    if (rd_en) rd_data_r <= stack_mem[rd_addr];
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.char_out     = out_char_r;
  assign out_chan.stack_length = out_len_r;
  assign out_chan.erased       = out_erased_r;
  assign out_chan.overflow     = out_ovf_r;
  assign out_chan.index_invalid = out_inv_r;

  always_comb begin
    top_inc   = top_r + TW'(1);
    eff_len_t = TW'(pat_info.eff_len);
    idx_ext   = XW'(in_chan.read_index);
    top_ext   = XW'(top_r);

    state_nxt      = state_r;
    top_nxt        = top_r;
    addr_nxt       = addr_r;
    pidx_nxt       = pidx_r;
    res_char_nxt   = res_char_r;
    res_erased_nxt = res_erased_r;
    res_ovf_nxt    = res_ovf_r;
    res_inv_nxt    = res_inv_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_len_nxt    = out_len_r;
    out_erased_nxt = out_erased_r;
    out_ovf_nxt    = out_ovf_r;
    out_inv_nxt    = out_inv_r;
    rd_en          = 1'b0;
    rd_addr        = addr_r;
    wr_en          = 1'b0;

    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          res_char_nxt   = '0;
          res_erased_nxt = 1'b0;
          res_ovf_nxt    = 1'b0;
          res_inv_nxt    = 1'b0;
          state_nxt      = S_EMIT;
          case (in_chan.req_type)
            spe_pkg::REQ_PUSH: begin
              if (top_r == TW'(STACK_DEPTH)) begin
                res_ovf_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                top_nxt = top_inc;
                if (in_chan.char_in == pat_info.last_char && top_inc >= eff_len_t) begin
                  if (pat_info.eff_len == PLW'(1)) begin
                    // single-character pattern: the pushed character goes at once
                    top_nxt        = top_r;
                    res_erased_nxt = 1'b1;
                  end else begin
                    rd_en     = 1'b1;
                    rd_addr   = AW'(top_r - TW'(1));
                    addr_nxt  = rd_addr;
                    pidx_nxt  = PW'(pat_info.eff_len - PLW'(2));
                    state_nxt = S_CMP;
                  end
                end
              end
            end
            spe_pkg::REQ_READ: begin
              if (idx_ext < top_ext) begin
                rd_en     = 1'b1;
                rd_addr   = idx_ext[AW-1:0];
                state_nxt = S_READ;
              end else begin
                res_inv_nxt = 1'b1;
              end
            end
            spe_pkg::REQ_CLEAR: top_nxt = '0;
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_char_nxt = rd_data_r;
        state_nxt    = S_EMIT;
      end
      S_CMP: begin
        if (rd_data_r != pat_char) begin
          state_nxt = S_EMIT;
        end else if (pidx_r == '0) begin
          top_nxt        = top_r - eff_len_t;
          res_erased_nxt = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          // advance one entry down the stack
          rd_en    = 1'b1;
          rd_addr  = addr_r - AW'(1);
          addr_nxt = rd_addr;
          pidx_nxt = pidx_r - PW'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = res_char_r;
          out_len_nxt    = LW'(top_r);
          out_erased_nxt = res_erased_r;
          out_ovf_nxt    = res_ovf_r;
          out_inv_nxt    = res_inv_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r       <= addr_nxt;
    pidx_r       <= pidx_nxt;
    res_char_r   <= res_char_nxt;
    res_erased_r <= res_erased_nxt;
    res_ovf_r    <= res_ovf_nxt;
    res_inv_r    <= res_inv_nxt;
    out_char_r   <= out_char_nxt;
    out_len_r    <= out_len_nxt;
    out_erased_r <= out_erased_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_inv_r    <= out_inv_nxt;
  end

endmodule

@@ tb/sv/stack_eraser_checker.sv @@
`timescale 1ns / 1ps

module stack_eraser_checker #(
  parameter int STACK_DEPTH = 4096,
  parameter int PATTERN_MAX = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  spe_in_if                              in_mon,
  spe_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             outstanding,
  output int                             depth_hint
);
  import spe_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              erased;
    logic              overflow;
    logic              bad_index;
  } survivor_reply_t;

  survivor_reply_t        replies_due[$];
  logic [CHAR_W-1:0]      stack_mem[STACK_DEPTH];
  int unsigned            stack_fill;
  logic [PLEN_W-1:0]      pat_len;
  logic [CFG_DATA_W-1:0]  pat_words[PAT_WORDS];
  int                     errors = 0;

  assign fail_count = errors;

  function automatic int pattern_span();
    if (pat_len == '0) return 1;
    if (pat_len > PATTERN_MAX) return PATTERN_MAX;
    return int'(pat_len);
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char(input int i);
    return pat_words[i >> 3][(i & 7) * 8 +: 8];
  endfunction

  // Update the stack copy for one request and return the reply it must produce.
  function automatic survivor_reply_t apply_request(input logic [1:0] req,
                                                    input logic [CHAR_W-1:0] c,
                                                    input logic [IDX_W-1:0] ix);
    survivor_reply_t r;
    int  n;
    bit  hit;
    r = '0;
    case (req)
      REQ_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          n = pattern_span();
          stack_mem[stack_fill] = c;
          stack_fill++;
          if (c == pattern_char(n - 1) && stack_fill >= n) begin
            hit = 1'b1;
            for (int k = 0; k < n; k++)
              if (stack_mem[stack_fill - 1 - k] != pattern_char(n - 1 - k)) hit = 1'b0;
            if (hit) begin
              stack_fill -= n;
              r.erased = 1'b1;
            end
          end
        end
      end
      REQ_READ: begin
        if (ix < stack_fill) r.ch = stack_mem[ix];
        else r.bad_index = 1'b1;
      end
      REQ_CLEAR: stack_fill = 0;
      default: ;
    endcase
    r.len = stack_fill[LEN_W-1:0];
    return r;
  endfunction

  function automatic void flag(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $time, what);
  endfunction

  always @(posedge clk) begin
    survivor_reply_t want;
    survivor_reply_t got;
    if (!rst_n) begin
      replies_due.delete();
      stack_fill = 0;
      pat_len = PLEN_W'(1);
      foreach (pat_words[k]) pat_words[k] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAT_LEN: pat_len = cfg_wdata[PLEN_W-1:0];
          CFG_PAT_W0:  pat_words[0] = cfg_wdata;
          CFG_PAT_W1:  pat_words[1] = cfg_wdata;
          CFG_PAT_W2:  pat_words[2] = cfg_wdata;
          CFG_PAT_W3:  pat_words[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        replies_due.insert(replies_due.size(),
                           apply_request(in_mon.req_type, in_mon.char_in,
                                         in_mon.read_index));
      if (out_mon.valid && out_mon.ready) begin
        got.ch        = out_mon.char_out;
        got.len       = out_mon.stack_length;
        got.erased    = out_mon.erased;
        got.overflow  = out_mon.overflow;
        got.bad_index = out_mon.index_invalid;
        if (replies_due.size() == 0) begin
          flag($sformatf("result beat with nothing pending: char %02h len %0d",
                         got.ch, got.len));
        end else begin
          want = replies_due.pop_front();
          if (got.ch !== want.ch || got.len !== want.len || got.erased !== want.erased ||
              got.overflow !== want.overflow || got.bad_index !== want.bad_index)
            flag($sformatf({"mismatch: expected char %02h len %0d erased %0b ovf %0b ",
                            "inv %0b, got char %02h len %0d erased %0b ovf %0b inv %0b"},
                           want.ch, want.len, want.erased, want.overflow, want.bad_index,
                           got.ch, got.len, got.erased, got.overflow, got.bad_index));
        end
      end
    end
    outstanding <= replies_due.size();
    depth_hint  <= stack_fill;
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import spe_pkg::*;

  localparam int              STACK_SLOTS  = 4096;
  localparam int              PATTERN_SLOTS = 32;
  localparam int              IDLE_LIMIT   = 2000;
  localparam int              HOLD_CYCLES  = 150;
  localparam logic [1:0]      REQ_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    outstanding;
  int                    depth_hint;

  int         items_sent = 0;
  bit         gaps_on;
  int         span;
  logic [7:0] pat[PATTERN_SLOTS];
  logic [7:0] alpha_base;
  int         alpha_size;

  spe_in_if  in_chan ();
  spe_out_if out_chan ();

  stack_pattern_eraser_unit #(
    .STACK_DEPTH(STACK_SLOTS),
    .PATTERN_MAX(PATTERN_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  stack_eraser_checker #(
    .STACK_DEPTH(STACK_SLOTS),
    .PATTERN_MAX(PATTERN_SLOTS)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .depth_hint (depth_hint)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [11:0] any_index();
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [7:0] alpha_char();
    return 8'(alpha_base + $urandom_range(0, alpha_size - 1));
  endfunction

  task automatic send(input logic [1:0] code, input logic [7:0] c, input logic [11:0] ix);
    int gap;
    gap = gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.req_type   <= code;
    in_chan.char_in    <= c;
    in_chan.read_index <= ix;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_read();
    logic [11:0] ix;
    if (depth_hint > 0 && $urandom_range(0, 3) != 0)
      ix = 12'($urandom_range(0, depth_hint - 1));
    else
      ix = any_index();
    send(REQ_READ, any_char(), ix);
  endtask

  // Drop valid on the accept step of the last beat, then wait for every reply.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  task automatic load_pattern(input logic [5:0] len_code, input bit stray);
    logic [CFG_DATA_W-1:0] w;
    write_reg(CFG_PAT_LEN, ({$urandom, $urandom} & ~64'h3F) | 64'(len_code));
    for (int k = 0; k < PAT_WORDS; k++) begin
      for (int b = 0; b < 8; b++) w[b * 8 +: 8] = pat[k * 8 + b];
      write_reg(CFG_IDX_W'(CFG_PAT_W0 + k), w);
    end
    if (stray) write_reg(CFG_IDX_W'(CFG_SPARE_LO + $urandom_range(0, 2)), {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // flat >= 0 gives a pattern of one repeated byte over all 32 slots
  task automatic setup_phase(input logic [5:0] len_code, input int letters, input int flat);
    drain();
    span       = (len_code == 0) ? 1 : ((len_code > PATTERN_SLOTS) ? PATTERN_SLOTS : len_code);
    alpha_size = (flat >= 0) ? 1 : letters;
    alpha_base = (flat >= 0) ? 8'(flat) : 8'($urandom_range(0, 251));
    for (int i = 0; i < PATTERN_SLOTS; i++)
      pat[i] = (flat >= 0 || i < span) ? alpha_char() : any_char();
    load_pattern(len_code, 1'($urandom_range(0, 1)));
    gaps_on = $urandom_range(0, 3) != 0;
  endtask

  // Nest copies of the pattern inside each other so the whole run cascades away.
  task automatic push_collapsing(input int nests);
    logic [7:0] seq[$];
    int         pos;
    for (int i = 0; i < span; i++) seq.insert(seq.size(), pat[i]);
    repeat (nests) begin
      pos = $urandom_range(0, seq.size());
      for (int i = span - 1; i >= 0; i--) seq.insert(pos, pat[i]);
    end
    foreach (seq[i]) begin
      send(REQ_PUSH, seq[i], any_index());
      if ($urandom_range(0, 9) == 0) send_read();
    end
  endtask

  task automatic push_broken();
    int cut;
    int slip;
    cut  = $urandom_range(1, span);
    slip = $urandom_range(0, 1) ? $urandom_range(0, cut - 1) : -1;
    for (int i = 0; i < cut; i++)
      send(REQ_PUSH, (i == slip) ? alpha_char() : pat[i], any_index());
  endtask

  task automatic run_phase(input int budget);
    int stop;
    int pick;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        push_collapsing(span > 8 ? $urandom_range(0, 1) : $urandom_range(0, 3));
      else if (pick < 65)
        push_broken();
      else if (pick < 80)
        send_read();
      else if (pick < 92)
        send(REQ_PUSH, $urandom_range(0, 1) ? alpha_char() : any_char(), any_index());
      else if (pick < 96)
        send(REQ_CLEAR, any_char(), any_index());
      else
        send(REQ_SPARE, any_char(), any_index());
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_chan.valid      <= 1'b0;
    in_chan.req_type   <= REQ_PUSH;
    in_chan.char_in    <= '0;
    in_chan.read_index <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset pattern is a single zero byte.
    gaps_on = 1'($urandom_range(0, 1));
    send(REQ_READ, 8'h00, 12'h000);
    send(REQ_PUSH, 8'h00, 12'hFFF);
    send(REQ_PUSH, 8'hFF, 12'h000);
    send(REQ_PUSH, 8'h01, 12'h000);
    send(REQ_READ, 8'hFF, 12'h000);
    send(REQ_READ, 8'h00, 12'h001);
    send(REQ_READ, 8'h00, 12'h002);
    send(REQ_READ, 8'h00, 12'hFFF);
    send(REQ_SPARE, 8'hFF, 12'hFFF);
    send(REQ_CLEAR, 8'hAA, 12'h555);
    send(REQ_READ, 8'h00, 12'h000);
    drain();
    for (int i = 0; i < PATTERN_SLOTS; i++) pat[i] = any_char();
    pat[0] = "x";
    pat[1] = "y";
    pat[2] = "z";
    load_pattern(6'd3, 1'b1);
    // last character alone on an empty stack: too short to match
    send(REQ_PUSH, "z", 12'h000);
    send(REQ_CLEAR, 8'h00, 12'h000);
    send(REQ_PUSH, "x", 12'h000);
    send(REQ_PUSH, "x", 12'h000);
    send(REQ_PUSH, "y", 12'h000);
    send(REQ_PUSH, "z", 12'h000);
    send(REQ_PUSH, "y", 12'h000);
    send(REQ_PUSH, "z", 12'h000);
    send(REQ_PUSH, "x", 12'h000);
    send(REQ_PUSH, "y", 12'h000);
    send(REQ_PUSH, "y", 12'h000);
    send(REQ_READ, 8'h00, 12'h000);
    send(REQ_READ, 8'h00, 12'h002);
    send(REQ_CLEAR, 8'h00, 12'h000);

    setup_phase(6'd2, 2, -1);
    run_phase(180);
    setup_phase(6'($urandom_range(3, 5)), 3, -1);
    run_phase(180);
    setup_phase(6'd32, 2, -1);
    run_phase(180);
    setup_phase(6'd0, 3, -1);
    run_phase(150);
    setup_phase(6'd63, 2, -1);
    run_phase(150);
    setup_phase(6'd8, 1, 255);
    run_phase(150);
    setup_phase(6'd4, 1, 0);
    run_phase(150);
    setup_phase(6'($urandom_range(33, 62)), 2, -1);
    run_phase(150);
    setup_phase(6'($urandom_range(6, 16)), 3, -1);
    run_phase(180);

    // Fill the stack to the brim with bytes that never match a lone zero pattern.
    setup_phase(6'd1, 1, 0);
    send(REQ_CLEAR, any_char(), any_index());
    for (int k = 0; k < STACK_SLOTS; k++)
      send(REQ_PUSH, 8'($urandom_range(1, 255)), any_index());
    send(REQ_PUSH, 8'h00, any_index());
    send(REQ_PUSH, any_char(), any_index());
    send(REQ_READ, any_char(), 12'(STACK_SLOTS - 1));
    send(REQ_READ, any_char(), 12'h000);
    send_read();
    send(REQ_SPARE, any_char(), any_index());
    send(REQ_CLEAR, any_char(), any_index());
    send(REQ_PUSH, 8'h00, any_index());

    drain();
    repeat (36) @(posedge clk);
    if (fail_count == 0)
      $display("** stack_pattern_eraser_unit: PASSED **");
    else
      $display("** stack_pattern_eraser_unit: FAILED **");
    $finish;
  end

  // Result side: random back-pressure, with two long holds to back the block up.
  initial begin
    int beats;
    int stall;
    bit lazy;
    beats = 0;
    lazy  = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (beats % 100 == 0) lazy = $urandom_range(0, 3) != 0;
      stall = lazy ? $urandom_range(0, 8) : 0;
      if (beats == 300 || beats == 1200) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      beats++;
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** stack_pattern_eraser_unit: FAILED **");
    $finish;
  end

endmodule
